// ----- hw/rtl/rvd_pkg.sv -----
// rvd_pkg: shared widths, constants, beat structs and the arctangent table
// for the 2D vector rotator. No dependencies.
`timescale 1ns / 1ps

package rvd_pkg;

  // Q16.16 degree constants
  localparam int unsigned TURN_Q16      = 23592960;   // 360 deg
  localparam int unsigned HALF_TURN_Q16 = 11796480;   // 180 deg
  localparam int unsigned QUARTER_Q16   = 5898240;    // 90 deg

  // CORDIC gain 0.60725..., unsigned Q0.32
  localparam logic [31:0] GAIN_Q32 = 32'd2608131496;

  localparam int unsigned DEF_CORDIC_STAGES = 24;
  localparam int unsigned MAX_CORDIC_STAGES = 32;

  // Angle reduction: offset by 92 turns so the value is never negative,
  // then a restoring remainder over 8 quotient bits.
  localparam int unsigned REDUCE_STEPS = 8;
  localparam int unsigned REM_W        = 33;
  localparam logic [REM_W-1:0] REDUCE_OFFSET = 33'd2170552320;  // 92 turns

  localparam int unsigned XY_W = 42;  // 8 guard fraction bits plus growth
  localparam int unsigned Z_W  = 33;  // residual angle, 2^-24 degree units

  // atan(2^-i) in 2^-24 degree units
  localparam logic [29:0] ATAN_Q24 [MAX_CORDIC_STAGES] = '{
    30'd754974720, 30'd445687602, 30'd235489088, 30'd119537938,
    30'd60000934,  30'd30029717,  30'd15018523,  30'd7509720,
    30'd3754917,   30'd1877466,   30'd938734,    30'd469367,
    30'd234684,    30'd117342,    30'd58671,     30'd29335,
    30'd14668,     30'd7334,      30'd3667,      30'd1833,
    30'd917,       30'd458,       30'd229,       30'd115,
    30'd57,        30'd29,        30'd14,        30'd7,
    30'd4,         30'd2,         30'd1,         30'd0
  };

  // Beat moving down the angle reduction chain
  typedef struct packed {
    logic                   valid;
    logic [REM_W-1:0]       rem;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
  } red_beat_t;

  // Beat moving down the CORDIC chain
  typedef struct packed {
    logic                   valid;
    logic                   flip;
    logic signed [Z_W-1:0]  z;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
  } rot_beat_t;

endpackage

// ----- hw/rtl/rotate_vector2d_by_degrees_top.sv -----
// Top level of the 2D vector rotator: gain multiply, angle reduction chain,
// quadrant fold, CORDIC chain, round and saturate. Depends on rvd_pkg,
// rvd_reduce_cell and rvd_cordic_cell.
`timescale 1ns / 1ps

// Rotates (vec_x_i, vec_y_i) counter-clockwise by angle_deg_i degrees, all
// signed Q16.16, and returns the saturated result on rot_x_o / rot_y_o with
// a one-cycle done_o strobe. The pipeline takes a new beat every cycle, so
// busy_o stays low; results must be captured when done_o is high, as the
// block cannot be held off. A rotated beat passes the gain multiply register,
// the eight-cell modulo-360 reduction chain, the quadrant fold register, one
// CORDIC cell per stage and the round and saturate register. With bypass set
// the vector comes back unchanged in the cycle after start. Write the bypass
// register only while no beat is in flight.

module rotate_vector2d_by_degrees_top #(
  parameter int unsigned CORDIC_STAGES = rvd_pkg::DEF_CORDIC_STAGES
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // bypass register
  input  logic               bypass_we_i,
  input  logic               bypass_wdata_i,
  // command side
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [31:0] vec_x_i,
  input  logic signed [31:0] vec_y_i,
  input  logic signed [31:0] angle_deg_i,
  // result side
  output logic               done_o,
  output logic signed [31:0] rot_x_o,
  output logic signed [31:0] rot_y_o
);
  import rvd_pkg::*;

  localparam logic [24:0] QUARTER  = 25'(QUARTER_Q16);
  localparam logic [24:0] UPPER    = 25'(TURN_Q16 - QUARTER_Q16);
  localparam logic signed [25:0] HALF_S = 26'(HALF_TURN_Q16);
  localparam logic signed [25:0] TURN_S = 26'(TURN_Q16);

  logic accept;
  logic bypass_q;

  // ---------------------------------------------------------------------
  // Bypass register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bypass_q <= 1'b0;
    end else if (bypass_we_i) begin
      bypass_q <= bypass_wdata_i;
    end
  end

  // Fully pipelined: every start is taken.
  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  // ---------------------------------------------------------------------
  // Front stage: gain multiply (floor shift by 24 keeps 8 guard bits) and
  // angle offset so the remainder chain only ever sees positive values.
  // ---------------------------------------------------------------------
  logic signed [65:0] prod_x, prod_y;
  logic [REM_W-1:0]   ang_off;
  red_beat_t          front_q;
  red_beat_t          red [REDUCE_STEPS+1];

  assign prod_x = $signed({{34{vec_x_i[31]}}, vec_x_i}) * $signed({34'd0, GAIN_Q32});
  assign prod_y = $signed({{34{vec_y_i[31]}}, vec_y_i}) * $signed({34'd0, GAIN_Q32});
  assign ang_off = REM_W'({angle_deg_i[31], angle_deg_i}) + REDUCE_OFFSET;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
    end else begin
      front_q.valid <= accept & ~bypass_q;
      front_q.rem   <= ang_off;
      front_q.x     <= prod_x[24 +: XY_W];
      front_q.y     <= prod_y[24 +: XY_W];
    end
  end

  assign red[0] = front_q;

  // ---------------------------------------------------------------------
  // Remainder chain: subtract 360 deg << k for k = 7 down to 0
  // ---------------------------------------------------------------------
  for (genvar g = 0; g < REDUCE_STEPS; g++) begin : g_red
    rvd_reduce_cell #(
      .K(REDUCE_STEPS - 1 - g)
    ) u_red (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .beat_i(red[g]),
      .beat_o(red[g+1])
    );
  end

  // ---------------------------------------------------------------------
  // Quadrant fold. m is in [0, 360). Up to +90 it stands; from -90 up it
  // wraps to negative; in between, half a turn comes off and the result is
  // negated at the end. Exactly +-90 takes no fold.
  // ---------------------------------------------------------------------
  logic [24:0]        m;
  logic signed [25:0] m_fold;
  logic               flip;
  rot_beat_t          fold_q;
  rot_beat_t          rot [CORDIC_STAGES+1];

  assign m = red[REDUCE_STEPS].rem[24:0];

  always_comb begin
    if (m <= QUARTER) begin
      m_fold = $signed({1'b0, m});
      flip   = 1'b0;
    end else if (m < UPPER) begin
      m_fold = $signed({1'b0, m}) - HALF_S;
      flip   = 1'b1;
    end else begin
      m_fold = $signed({1'b0, m}) - TURN_S;
      flip   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_q <= '0;
    end else begin
      fold_q.valid <= red[REDUCE_STEPS].valid;
      fold_q.flip  <= flip;
      fold_q.z     <= {m_fold[24:0], 8'd0};  // to 2^-24 degree units
      fold_q.x     <= red[REDUCE_STEPS].x;
      fold_q.y     <= red[REDUCE_STEPS].y;
    end
  end

  assign rot[0] = fold_q;

  // ---------------------------------------------------------------------
  // CORDIC chain, one micro-rotation per cell
  // ---------------------------------------------------------------------
  for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_rot
    rvd_cordic_cell #(
      .SHIFT(s)
    ) u_rot (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .beat_i(rot[s]),
      .beat_o(rot[s+1])
    );
  end

  // ---------------------------------------------------------------------
  // Output: optional negate, round half up, saturate to 32 bits.
  // A bypass beat and a rotated beat never meet here while the register is
  // only written when idle; the rotated one wins should they ever do.
  // ---------------------------------------------------------------------
  rot_beat_t          last;
  logic signed [42:0] sum_x, sum_y;
  logic signed [34:0] rnd_x, rnd_y;
  logic signed [31:0] sat_x, sat_y;
  logic               done_d, done_q;
  logic signed [31:0] rot_x_d, rot_x_q, rot_y_d, rot_y_q;

  assign last  = rot[CORDIC_STAGES];
  assign sum_x = (last.flip ? -43'(last.x) : 43'(last.x)) + 43'sd128;
  assign sum_y = (last.flip ? -43'(last.y) : 43'(last.y)) + 43'sd128;
  assign rnd_x = sum_x[42:8];
  assign rnd_y = sum_y[42:8];

  always_comb begin
    if (rnd_x[34:31] == 4'b0000 || rnd_x[34:31] == 4'b1111) begin
      sat_x = rnd_x[31:0];
    end else begin
      sat_x = rnd_x[34] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
    if (rnd_y[34:31] == 4'b0000 || rnd_y[34:31] == 4'b1111) begin
      sat_y = rnd_y[31:0];
    end else begin
      sat_y = rnd_y[34] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
  end

  assign done_d  = last.valid | (accept & bypass_q);
  assign rot_x_d = last.valid ? sat_x : vec_x_i;
  assign rot_y_d = last.valid ? sat_y : vec_y_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rot_x_q <= rot_x_d;
    rot_y_q <= rot_y_d;
  end

  assign done_o  = done_q;
  assign rot_x_o = rot_x_q;
  assign rot_y_o = rot_y_q;

endmodule

// ----- hw/rtl/rvd_reduce_cell.sv -----
// rvd_reduce_cell: one restoring step of the modulo-360 angle reduction.
// Depends on rvd_pkg.
`timescale 1ns / 1ps

module rvd_reduce_cell #(
  parameter int unsigned K = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rvd_pkg::red_beat_t beat_i,
  output rvd_pkg::red_beat_t beat_o
);
  import rvd_pkg::*;

  localparam logic [REM_W-1:0] STEP = REM_W'(64'(TURN_Q16) << K);

  red_beat_t beat_d, beat_q;

  always_comb begin
    beat_d = beat_i;
    if (beat_i.rem >= STEP) begin
      beat_d.rem = beat_i.rem - STEP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q <= '0;
    end else begin
      beat_q <= beat_d;
    end
  end

  assign beat_o = beat_q;

endmodule

// ----- hw/rtl/rvd_cordic_cell.sv -----
// rvd_cordic_cell: one CORDIC micro-rotation in rotation mode.
// Depends on rvd_pkg.
`timescale 1ns / 1ps

module rvd_cordic_cell #(
  parameter int unsigned SHIFT = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rvd_pkg::rot_beat_t beat_i,
  output rvd_pkg::rot_beat_t beat_o
);
  import rvd_pkg::*;

  localparam logic signed [Z_W-1:0] ATAN = Z_W'(ATAN_Q24[SHIFT[4:0]]);

  logic signed [XY_W-1:0] dx, dy;
  rot_beat_t beat_d, beat_q;

  assign dx = beat_i.y >>> SHIFT;
  assign dy = beat_i.x >>> SHIFT;

  always_comb begin
    beat_d = beat_i;
    if (!beat_i.z[Z_W-1]) begin
      beat_d.x = beat_i.x - dx;
      beat_d.y = beat_i.y + dy;
      beat_d.z = beat_i.z - ATAN;
    end else begin
      beat_d.x = beat_i.x + dx;
      beat_d.y = beat_i.y - dy;
      beat_d.z = beat_i.z + ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q <= '0;
    end else begin
      beat_q <= beat_d;
    end
  end

  assign beat_o = beat_q;

endmodule

// ----- hw/rtl/rvd_checker.sv -----
// rvd_checker: port-level assertions for the 2D vector rotator, bound to
// rotate_vector2d_by_degrees_top. Depends on rvd_pkg.
`timescale 1ns / 1ps

module rvd_checker #(
  parameter int unsigned CORDIC_STAGES = rvd_pkg::DEF_CORDIC_STAGES
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               bypass_we_i,
  input logic               bypass_wdata_i,
  input logic               start_i,
  input logic               busy_o,
  input logic signed [31:0] vec_x_i,
  input logic signed [31:0] vec_y_i,
  input logic               done_o,
  input logic signed [31:0] rot_x_o,
  input logic signed [31:0] rot_y_o
);
  import rvd_pkg::*;

  localparam int unsigned LATENCY = CORDIC_STAGES + REDUCE_STEPS + 3;

  logic byp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (bypass_we_i) begin
      byp_q <= bypass_wdata_i;
    end
  end

  // A bypassed beat is answered on the next cycle.
  a_bypass_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && byp_q |=> done_o)
    else $error("bypass beat not answered next cycle");

  // A rotated beat comes out after the full pipeline latency.
  a_rot_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && !byp_q |-> ##LATENCY done_o)
    else $error("rotated beat missing at pipeline latency");

  // The zero vector stays zero for any angle.
  a_zero_vec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && !byp_q && vec_x_i == 32'sd0 && vec_y_i == 32'sd0
    |-> ##LATENCY (rot_x_o == 32'sd0 && rot_y_o == 32'sd0))
    else $error("zero vector rotated to non-zero");

  // The block never stalls the command side.
  a_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o)
    else $error("busy raised");

endmodule

bind rotate_vector2d_by_degrees_top rvd_checker #(
  .CORDIC_STAGES(CORDIC_STAGES)
) u_rvd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .bypass_we_i   (bypass_we_i),
  .bypass_wdata_i(bypass_wdata_i),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .vec_x_i       (vec_x_i),
  .vec_y_i       (vec_y_i),
  .done_o        (done_o),
  .rot_x_o       (rot_x_o),
  .rot_y_o       (rot_y_o)
);

// ----- bench/rotate_vector2d_by_degrees_top_tb.sv -----
// Self-checking bench for rotate_vector2d_by_degrees_top: directed and random
// vector/angle beats, bypass register phases, in-bench CORDIC prediction.
// Depends only on the rotator RTL (rvd_pkg is pulled in by the block itself).
`timescale 1ns / 1ps

module rotate_vector2d_by_degrees_top_tb;

  // ---------------------------------------------------------------------------
  // Block configuration and fixed-point constants for the prediction
  // ---------------------------------------------------------------------------
  localparam int unsigned CORDIC_STAGES = 24;
  // pipeline depth of the block
  localparam int unsigned PIPE_DEPTH    = CORDIC_STAGES + 11;
  localparam int unsigned CYCLE_LIMIT   = 200000;

  localparam bit ROTATE_ON    = 1'b0;
  localparam bit PASS_THROUGH = 1'b1;

  localparam int     DEG        = 65536;                 // 1 degree in Q16.16
  localparam longint FULL_TURN  = 64'sd23592960;
  localparam longint HALF_TURN  = 64'sd11796480;
  localparam longint QTR_TURN   = 64'sd5898240;
  localparam longint ROT_GAIN   = 64'sd2608131496;       // 0.60725.. in Q0.32
  localparam longint Q16_MAX    = 64'sd2147483647;
  localparam longint Q16_MIN    = -64'sd2147483648;

  localparam logic signed [31:0] VMAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] VMIN = 32'sh8000_0000;

  // atan(2^-i), units of 2^-24 degree
  localparam longint ARCTAN_Q24 [32] = '{
    754974720, 445687602, 235489088, 119537938,
    60000934,  30029717,  15018523,  7509720,
    3754917,   1877466,   938734,    469367,
    234684,    117342,    58671,     29335,
    14668,     7334,      3667,      1833,
    917,       458,       229,       115,
    57,        29,        14,        7,
    4,         2,         1,         0
  };

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } rot_pair_t;

  // ---------------------------------------------------------------------------
  // Ledger of rotated vectors still owed by the block.
  // Keeps its own copy of the bypass bit, updated at the edge that writes it.
  // ---------------------------------------------------------------------------
  class rotation_ledger;
    rot_pair_t   owed[$];
    bit          bypass;
    int unsigned faults;

    function new();
      bypass = ROTATE_ON;
      faults = 0;
    endfunction

    // Bit-exact CORDIC rotation: fold to +-90 deg, gain, micro-rotations,
    // optional negate, round half up, saturate.
    function rot_pair_t rotate_q16(logic signed [31:0] vx, logic signed [31:0] vy,
                                   logic signed [31:0] ang);
      rot_pair_t res;
      longint    m, x, y, z, dx, dy, rx, ry;
      bit        flip;
      flip = 1'b0;
      m = longint'(ang) % FULL_TURN;
      if (m < 0) m += FULL_TURN;
      if (m >= HALF_TURN) m -= FULL_TURN;
      if (m > QTR_TURN) begin
        m -= HALF_TURN;
        flip = 1'b1;
      end else if (m < -QTR_TURN) begin
        m += HALF_TURN;
        flip = 1'b1;
      end
      z = m * 256;
      x = (longint'(vx) * ROT_GAIN) >>> 24;
      y = (longint'(vy) * ROT_GAIN) >>> 24;
      for (int i = 0; i < CORDIC_STAGES; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x = x - dx;
          y = y + dy;
          z = z - ARCTAN_Q24[i];
        end else begin
          x = x + dx;
          y = y - dy;
          z = z + ARCTAN_Q24[i];
        end
      end
      if (flip) begin
        x = -x;
        y = -y;
      end
      rx = (x + 128) >>> 8;
      ry = (y + 128) >>> 8;
      if (rx > Q16_MAX) rx = Q16_MAX;
      if (rx < Q16_MIN) rx = Q16_MIN;
      if (ry > Q16_MAX) ry = Q16_MAX;
      if (ry < Q16_MIN) ry = Q16_MIN;
      res.x = rx[31:0];
      res.y = ry[31:0];
      return res;
    endfunction

    function void log_vector(logic signed [31:0] vx, logic signed [31:0] vy,
                             logic signed [31:0] ang);
      rot_pair_t p;
      if (bypass) begin
        p.x = vx;
        p.y = vy;
      end else begin
        p = rotate_q16(vx, vy, ang);
      end
      owed.push_back(p);
    endfunction

    function void note_fault();
      faults++;
    endfunction

    function void check_rotated(logic signed [31:0] rx, logic signed [31:0] ry);
      rot_pair_t p;
      if (owed.size() == 0) begin
        faults++;
        $error("result beat with nothing owed: rot_x=%0d rot_y=%0d", rx, ry);
        return;
      end
      p = owed.pop_front();
      if (rx !== p.x) begin
        faults++;
        $error("rot_x: expected %0d, got %0d", p.x, rx);
      end
      if (ry !== p.y) begin
        faults++;
        $error("rot_y: expected %0d, got %0d", p.y, ry);
      end
    endfunction

    function int unsigned waiting();
      return owed.size();
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // DUT hookup
  // ---------------------------------------------------------------------------
  logic               clk_i;
  logic               rst_ni;
  logic               bypass_we_i;
  logic               bypass_wdata_i;
  logic               start_i;
  logic               busy_o;
  logic signed [31:0] vec_x_i;
  logic signed [31:0] vec_y_i;
  logic signed [31:0] angle_deg_i;
  logic               done_o;
  logic signed [31:0] rot_x_o;
  logic signed [31:0] rot_y_o;

  rotate_vector2d_by_degrees_top #(
    .CORDIC_STAGES(CORDIC_STAGES)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .bypass_we_i   (bypass_we_i),
    .bypass_wdata_i(bypass_wdata_i),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .vec_x_i       (vec_x_i),
    .vec_y_i       (vec_y_i),
    .angle_deg_i   (angle_deg_i),
    .done_o        (done_o),
    .rot_x_o       (rot_x_o),
    .rot_y_o       (rot_y_o)
  );

  rotation_ledger ledger;
  int unsigned    cycle_count;
  bit             calm;        // set during the stretch without sender gaps

  // 4 ns clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Monitor: everything sampled at the rising edge, before the block's own
  // updates land, so input acceptance and result strobes see pre-edge values.
  // A beat taken at a register-write edge still sees the old bypass value.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) ledger.log_vector(vec_x_i, vec_y_i, angle_deg_i);
      if (done_o) ledger.check_rotated(rot_x_o, rot_y_o);
      if (bypass_we_i) ledger.bypass = bypass_wdata_i;
    end
  end

  // Watchdog: generous bound over the slowest legal run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side. All driving happens at the falling edge; each task leaves
  // time at a falling edge with no assignment yet made in that step.
  // ---------------------------------------------------------------------------

  // Offer one beat and hold it until the block takes it. busy_o seen at the
  // falling edge is what the next rising edge will use.
  task automatic send_vector(logic signed [31:0] vx, logic signed [31:0] vy,
                             logic signed [31:0] ang);
    start_i     <= 1'b1;
    vec_x_i     <= vx;
    vec_y_i     <= vy;
    angle_deg_i <= ang;
    #0;
    while (busy_o) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  // Sender gap; payload lines carry noise meanwhile
  task automatic idle_cycles(int unsigned n);
    start_i     <= 1'b0;
    vec_x_i     <= $urandom;
    vec_y_i     <= $urandom;
    angle_deg_i <= $urandom;
    repeat (n) @(negedge clk_i);
  endtask

  // Random gap before a beat, roughly a fifth of all cycles
  task automatic pace();
    if (!calm && $urandom_range(99) < 18) idle_cycles($urandom_range(1, 2));
  endtask

  // Stop sending and let every owed result come home
  task automatic drain();
    idle_cycles(1);
    while (ledger.waiting() != 0) @(negedge clk_i);
  endtask

  // Bypass register write, only with the pipeline empty
  task automatic write_bypass(bit b);
    drain();
    bypass_we_i    <= 1'b1;
    bypass_wdata_i <= b;
    @(negedge clk_i);
    bypass_we_i    <= 1'b0;
    bypass_wdata_i <= $urandom_range(1);
    @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Random field shapes: full range, small and mid-sized vectors, the
  // extremes, and angles clustered on the quarter-turn fold boundaries.
  // ---------------------------------------------------------------------------
  function automatic logic signed [31:0] pick_coord();
    case ($urandom_range(4)) inside
      0, 1:    return $urandom;
      2:       return $signed($urandom_range(0, 2 << 20)) - (1 << 20);
      3:       return $signed($urandom_range(0, 2 << 28)) - (1 << 28);
      default: begin
        case ($urandom_range(4))
          0:       return VMAX;
          1:       return VMIN;
          2:       return 32'sd0;
          3:       return -32'sd1;
          default: return 32'sd65536;
        endcase
      end
    endcase
  endfunction

  function automatic logic signed [31:0] pick_angle();
    int k;
    case ($urandom_range(5))
      0:       return $urandom;
      1:       return $signed($urandom_range(0, 720 * DEG)) - 360 * DEG;
      2: begin
        // right on or just beside a quarter-turn multiple
        k = $signed($urandom_range(0, 8)) - 4;
        return k * 90 * DEG + ($signed($urandom_range(0, 8)) - 4);
      end
      3: begin
        // near a whole number of turns, kept inside the 32-bit range
        k = $signed($urandom_range(0, 180)) - 90;
        return k * 360 * DEG + ($signed($urandom_range(0, 2 * DEG)) - DEG);
      end
      4: begin
        k = $signed($urandom_range(0, 16)) - 8;
        return k * 45 * DEG;
      end
      default: return $signed($urandom_range(0, 1440 * DEG)) - 720 * DEG;
    endcase
  endfunction

  task automatic random_beats(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      pace();
      send_vector(pick_coord(), pick_coord(), pick_angle());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    ledger         = new();
    cycle_count    = 0;
    calm           = 1'b0;
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    bypass_we_i    = 1'b0;
    bypass_wdata_i = 1'b0;
    vec_x_i        = '0;
    vec_y_i        = '0;
    angle_deg_i    = '0;

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: quarter turns, fold boundaries, wrap, saturation, extremes
    send_vector(32'sd65536, 32'sd0, 32'sd0);
    send_vector(32'sd65536, 32'sd0, 90 * DEG);             // exactly +90, no fold
    send_vector(32'sd65536, 32'sd0, -90 * DEG);            // exactly -90, no fold
    send_vector(32'sd65536, 32'sd0, 180 * DEG);
    send_vector(32'sd65536, 32'sd0, -180 * DEG);
    send_vector(32'sd0, 32'sd65536, 270 * DEG);
    send_vector(32'sd65536, 32'sd65536, 360 * DEG);
    send_vector(32'sd65536, 32'sd0, 90 * DEG + 1);         // just past the fold
    send_vector(32'sd65536, 32'sd0, -90 * DEG - 1);
    send_vector(32'sd229376, -32'sd147456, 45 * DEG);
    send_vector(VMIN, 32'sd0, 180 * DEG);                  // negation saturates
    send_vector(VMAX, VMAX, 45 * DEG);                     // growth saturates
    send_vector(VMIN, VMIN, 45 * DEG);
    send_vector(VMAX, VMIN, -135 * DEG);
    send_vector(32'sd0, 32'sd0, VMAX);
    send_vector(-32'sd1, 32'sd1, VMIN);                    // most negative angle
    send_vector(32'sd12345, -32'sd67890, VMAX);
    send_vector(32'sd1, -32'sd1, 32'sd1);                  // tiniest angle
    send_vector(32'sd65536, 32'sd0, -32'sd1);
    send_vector(VMAX, 32'sd0, 750 * DEG);
    send_vector(VMIN, VMAX, -1000 * DEG);
    send_vector(32'sh7FFF_0000, -32'sh7FFF_0000, 135 * DEG);

    // Random, rotation on; a gap-free stretch and a full drain in the middle
    random_beats(350);
    calm = 1'b1;
    random_beats(250);
    calm = 1'b0;
    drain();
    random_beats(250);

    // Pass-through phase, then back and forth across both register values
    write_bypass(PASS_THROUGH);
    send_vector(VMIN, VMAX, 180 * DEG);
    random_beats(200);
    write_bypass(ROTATE_ON);
    random_beats(350);
    write_bypass(PASS_THROUGH);
    random_beats(100);
    write_bypass(ROTATE_ON);
    random_beats(100);

    // Wind down: let owed results arrive, then stay quiet and check that nothing is owed
    drain();
    repeat (PIPE_DEPTH + 8) @(negedge clk_i);
    if (ledger.waiting() != 0) begin
      ledger.note_fault();
      $error("%0d results never arrived", ledger.waiting());
    end

    if (ledger.faults == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
